@@ hw/rtl/tcbsp_pkg.sv @@
// Shared constants and types for the TCB spline point evaluator.
`default_nettype none

package tcbsp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int PARAM_WIDTH = 16;
  localparam int SHAPE_WIDTH = 16;
  localparam int SHAPE_FRAC  = SHAPE_WIDTH - 2;

  // APB register map
  localparam int NUM_REGS    = 3;
  localparam int IDX_W       = $clog2(NUM_REGS);
  localparam int ADDR_W      = IDX_W + 2;
  localparam int DATA_W      = 32;

  // datapath widths
  localparam int FACT_W      = SHAPE_WIDTH + 1;          // 1 +/- shape value
  localparam int WT_W        = SHAPE_WIDTH + 4;          // tangent weight
  localparam int DIFF_W      = COORD_WIDTH + 1;          // control point difference
  localparam int TP_W        = WT_W + DIFF_W;            // weight * difference
  localparam int TSUM_W      = TP_W + 1;
  localparam int TAN_W       = TSUM_W - SHAPE_FRAC;      // rounded tangent
  localparam int H_W         = PARAM_WIDTH + 2;          // Hermite basis value
  localparam int HP_W        = H_W + COORD_WIDTH;        // basis * point
  localparam int HT_W        = H_W + TAN_W;              // basis * tangent
  localparam int ACC_W       = HT_W + 2;
  localparam int RES_W       = ACC_W - PARAM_WIDTH;

  typedef enum logic [IDX_W-1:0] {
    REG_TENSION    = 2'd0,
    REG_CONTINUITY = 2'd1,
    REG_BIAS       = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [WT_W-1:0] w0;  // (1-t)(1+b)(1-c)/2, start tangent, incoming diff
    logic signed [WT_W-1:0] w1;  // (1-t)(1-b)(1+c)/2, start tangent, segment diff
    logic signed [WT_W-1:0] w2;  // (1-t)(1+b)(1+c)/2, end tangent, segment diff
    logic signed [WT_W-1:0] w3;  // (1-t)(1-b)(1-c)/2, end tangent, outgoing diff
  } weights_t;

  typedef struct packed {
    logic signed [H_W-1:0] h00;
    logic signed [H_W-1:0] h01;
    logic signed [H_W-1:0] h10;
    logic signed [H_W-1:0] h11;
  } basis_t;

  typedef struct packed {
    logic adv;  // whole pipeline moves one stage
  } pipe_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcbsp_weights.sv @@
// Shape registers on the APB port and the tangent weight pipeline.
`default_nettype none

module tcbsp_weights
  import tcbsp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output weights_t               wt
);

  localparam int WPROD_W = 3 * FACT_W;
  localparam int WSHIFT  = 2 * SHAPE_FRAC + 1;
  localparam logic signed [WPROD_W-1:0] W_RND = WPROD_W'(1) << (WSHIFT - 1);
  localparam logic signed [FACT_W-1:0]  F_ONE = FACT_W'(1) << SHAPE_FRAC;

  logic signed [SHAPE_WIDTH-1:0] tension_r, tension_nxt;
  logic signed [SHAPE_WIDTH-1:0] continuity_r, continuity_nxt;
  logic signed [SHAPE_WIDTH-1:0] bias_r, bias_nxt;
  reg_idx_t                      idx;
  logic                          wr_en;

  logic signed [FACT_W-1:0]   omt, opb, omb, opc, omc;
  logic signed [2*FACT_W-1:0] pa_r, pb_r;
  logic signed [FACT_W-1:0]   opc_r, omc_r;
  logic signed [WPROD_W-1:0]  q0, q1, q2, q3;
  weights_t                   wt_r;

  function automatic logic signed [WT_W-1:0] round_w(input logic signed [WPROD_W-1:0] p);
    logic signed [WPROD_W-1:0] r;
    r = (p + W_RND) >>> WSHIFT;
    return r[WT_W-1:0];
  endfunction

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    tension_nxt    = tension_r;
    continuity_nxt = continuity_r;
    bias_nxt       = bias_r;
    prdata         = '0;
    unique case (idx)
      REG_TENSION: begin
        prdata = DATA_W'(unsigned'(tension_r));
        if (wr_en) tension_nxt = pwdata[SHAPE_WIDTH-1:0];
      end
      REG_CONTINUITY: begin
        prdata = DATA_W'(unsigned'(continuity_r));
        if (wr_en) continuity_nxt = pwdata[SHAPE_WIDTH-1:0];
      end
      REG_BIAS: begin
        prdata = DATA_W'(unsigned'(bias_r));
        if (wr_en) bias_nxt = pwdata[SHAPE_WIDTH-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r    <= '0;
      continuity_r <= '0;
      bias_r       <= '0;
    end else begin
      tension_r    <= tension_nxt;
      continuity_r <= continuity_nxt;
      bias_r       <= bias_nxt;
    end
  end

  // shape factors, one bit wider than the register so that 1 - (-2) fits
  always_comb begin
    omt = F_ONE - FACT_W'(tension_r);
    opb = F_ONE + FACT_W'(bias_r);
    omb = F_ONE - FACT_W'(bias_r);
    opc = F_ONE + FACT_W'(continuity_r);
    omc = F_ONE - FACT_W'(continuity_r);
  end

  // free running: register writes reach wt through the pa_r/pb_r and then the wt_r registers
  always_ff @(posedge clk) begin
    pa_r  <= omt * opb;
    pb_r  <= omt * omb;
    opc_r <= opc;
    omc_r <= omc;
  end

  always_comb begin
    q0 = pa_r * omc_r;
    q1 = pb_r * opc_r;
    q2 = pa_r * opc_r;
    q3 = pb_r * omc_r;
  end

  always_ff @(posedge clk) begin
    wt_r.w0 <= round_w(q0);
    wt_r.w1 <= round_w(q1);
    wt_r.w2 <= round_w(q2);
    wt_r.w3 <= round_w(q3);
  end

  assign wt = wt_r;

endmodule

`default_nettype wire

@@ hw/rtl/tcbsp_basis.sv @@
// Cubic Hermite basis values from the curve parameter, four register stages.
`default_nettype none

module tcbsp_basis
  import tcbsp_pkg::*;
(
  input  wire logic                   clk,
  input  wire pipe_ctl_t              ctl,
  input  wire logic [PARAM_WIDTH-1:0] u,
  output basis_t                      h
);

  localparam logic signed [H_W-1:0] H_ONE = H_W'(1) << PARAM_WIDTH;

  logic [2*PARAM_WIDTH-1:0] uu_r, u3p_r;
  logic [PARAM_WIDTH-1:0]   u_s2_r, u_s3_r, u2_r;
  logic signed [H_W-1:0]    ue, u2e, u3e;
  basis_t                   h_nxt, h_s4_r, h_s5_r;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      uu_r   <= u * u;
      u_s2_r <= u;
      u2_r   <= uu_r[2*PARAM_WIDTH-1:PARAM_WIDTH];
      u3p_r  <= uu_r[2*PARAM_WIDTH-1:PARAM_WIDTH] * u_s2_r;
      u_s3_r <= u_s2_r;
      h_s4_r <= h_nxt;
      h_s5_r <= h_s4_r;
    end
  end

  // intermediate terms may wrap; every final value fits H_W
  always_comb begin
    ue  = signed'(H_W'(u_s3_r));
    u2e = signed'(H_W'(u2_r));
    u3e = signed'(H_W'(u3p_r[2*PARAM_WIDTH-1:PARAM_WIDTH]));
    h_nxt.h00 = (u3e <<< 1) - (u2e + (u2e <<< 1)) + H_ONE;
    h_nxt.h01 = (u2e + (u2e <<< 1)) - (u3e <<< 1);
    h_nxt.h10 = u3e - (u2e <<< 1) + ue;
    h_nxt.h11 = u3e - u2e;
  end

  assign h = h_s5_r;

endmodule

`default_nettype wire

@@ hw/rtl/tcbsp_axis.sv @@
// One coordinate axis: tangents, Hermite sum, rounding and saturation.
`default_nettype none

module tcbsp_axis
  import tcbsp_pkg::*;
(
  input  wire logic                          clk,
  input  wire pipe_ctl_t                     ctl,
  input  wire logic signed [COORD_WIDTH-1:0] p0,
  input  wire logic signed [COORD_WIDTH-1:0] p1,
  input  wire logic signed [COORD_WIDTH-1:0] p2,
  input  wire logic signed [COORD_WIDTH-1:0] p3,
  input  wire weights_t                      wt,
  input  wire basis_t                        h,
  output logic signed [COORD_WIDTH-1:0]      curve,
  output logic                               clip
);

  localparam logic signed [TSUM_W-1:0] T_RND = TSUM_W'(1) << (SHAPE_FRAC - 1);
  localparam logic signed [ACC_W-1:0]  A_RND = ACC_W'(1) << (PARAM_WIDTH - 1);

  logic signed [DIFF_W-1:0]      d01_s2_r, d12_s2_r, d23_s2_r;
  logic signed [DIFF_W-1:0]      d01_s3_r, d12_s3_r, d23_s3_r;
  logic signed [COORD_WIDTH-1:0] p1_s2_r, p1_s3_r, p1_s4_r, p1_s5_r;
  logic signed [COORD_WIDTH-1:0] p2_s2_r, p2_s3_r, p2_s4_r, p2_s5_r;
  logic signed [TP_W-1:0]        m0_r, m1_r, m2_r, m3_r;
  logic signed [TSUM_W-1:0]      ts_sum, td_sum, ts_full, td_full;
  logic signed [TAN_W-1:0]       ts_r, td_r;
  logic signed [HP_W-1:0]        hp1_r, hp2_r;
  logic signed [HT_W-1:0]        hts_r, htd_r;
  logic signed [ACC_W-1:0]       sa_r, sb_r, acc, acc_sh;
  logic signed [RES_W-1:0]       v;
  logic [RES_W-COORD_WIDTH:0]    v_top;
  logic                          ovf;
  logic signed [COORD_WIDTH-1:0] curve_r, curve_nxt;
  logic                          clip_r, clip_nxt;

  always_comb begin
    ts_sum  = TSUM_W'(m0_r) + TSUM_W'(m1_r);
    td_sum  = TSUM_W'(m2_r) + TSUM_W'(m3_r);
    ts_full = (ts_sum + T_RND) >>> SHAPE_FRAC;
    td_full = (td_sum + T_RND) >>> SHAPE_FRAC;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      // s2: differences
      d01_s2_r <= DIFF_W'(p1) - DIFF_W'(p0);
      d12_s2_r <= DIFF_W'(p2) - DIFF_W'(p1);
      d23_s2_r <= DIFF_W'(p3) - DIFF_W'(p2);
      p1_s2_r  <= p1;
      p2_s2_r  <= p2;
      // s3: wait for the basis
      d01_s3_r <= d01_s2_r;
      d12_s3_r <= d12_s2_r;
      d23_s3_r <= d23_s2_r;
      p1_s3_r  <= p1_s2_r;
      p2_s3_r  <= p2_s2_r;
      // s4: weighted differences
      m0_r     <= wt.w0 * d01_s3_r;
      m1_r     <= wt.w1 * d12_s3_r;
      m2_r     <= wt.w2 * d12_s3_r;
      m3_r     <= wt.w3 * d23_s3_r;
      p1_s4_r  <= p1_s3_r;
      p2_s4_r  <= p2_s3_r;
      // s5: rounded tangents
      ts_r     <= ts_full[TAN_W-1:0];
      td_r     <= td_full[TAN_W-1:0];
      p1_s5_r  <= p1_s4_r;
      p2_s5_r  <= p2_s4_r;
      // s6: basis products
      hp1_r    <= h.h00 * p1_s5_r;
      hp2_r    <= h.h01 * p2_s5_r;
      hts_r    <= h.h10 * ts_r;
      htd_r    <= h.h11 * td_r;
      // s7: partial sums
      sa_r     <= ACC_W'(hp1_r) + ACC_W'(hp2_r);
      sb_r     <= ACC_W'(hts_r) + ACC_W'(htd_r);
      // s8: result
      curve_r  <= curve_nxt;
      clip_r   <= clip_nxt;
    end
  end

  always_comb begin
    acc    = sa_r + sb_r;
    acc_sh = (acc + A_RND) >>> PARAM_WIDTH;
    v      = acc_sh[RES_W-1:0];
    v_top  = v[RES_W-1:COORD_WIDTH-1];
    ovf    = !((&v_top) || !(|v_top));
    clip_nxt = ovf;
    if (ovf) begin
      curve_nxt = v[RES_W-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                             : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else begin
      curve_nxt = v[COORD_WIDTH-1:0];
    end
  end

  assign curve = curve_r;
  assign clip  = clip_r;

endmodule

`default_nettype wire

@@ hw/rtl/tcb_spline_point_eval_unit.sv @@
// Top level of the TCB spline point evaluator.
// Evaluates one 2D point of a Kochanek-Bartels spline segment from P1 to P2
// per transaction. The datapath is an eight-stage pipeline that takes one
// point per cycle unless stalled; a result appears on out_valid once its
// input transaction has passed through stages s1 to s8. Latency is
// set by the multiplier chain: u*u, u^2*u, weight*difference, basis*value,
// then a two-level add with rounding and saturation. A held output stalls
// every stage at once, so in_ready drops only while out_valid is high and
// out_ready is low. The tension, continuity and bias registers feed a
// separate two-stage weight pipeline; new values reach items accepted in
// the same cycle as the register write or later.
`default_nettype none

module tcb_spline_point_eval_unit
  import tcbsp_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [PARAM_WIDTH-1:0]        in_param_u,
  input  wire logic signed [COORD_WIDTH-1:0] in_p0_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_p0_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_p1_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_p1_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_p2_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_p2_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_p3_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_p3_y,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_curve_x,
  output logic signed [COORD_WIDTH-1:0]      out_curve_y,
  output logic                               out_clipped,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]                  prdata,
  output logic                               pready
);

  localparam int NSTG = 7;  // valid bits for stages one to seven

  pipe_ctl_t ctl;
  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;

  logic [PARAM_WIDTH-1:0]        u_s1_r;
  logic signed [COORD_WIDTH-1:0] p0x_s1_r, p0y_s1_r, p1x_s1_r, p1y_s1_r;
  logic signed [COORD_WIDTH-1:0] p2x_s1_r, p2y_s1_r, p3x_s1_r, p3y_s1_r;

  weights_t wt;
  basis_t   h;
  logic     clip_x, clip_y;

  assign ctl.adv  = !out_valid_r || out_ready;
  assign in_ready = ctl.adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      u_s1_r   <= in_param_u;
      p0x_s1_r <= in_p0_x;
      p0y_s1_r <= in_p0_y;
      p1x_s1_r <= in_p1_x;
      p1y_s1_r <= in_p1_y;
      p2x_s1_r <= in_p2_x;
      p2y_s1_r <= in_p2_y;
      p3x_s1_r <= in_p3_x;
      p3y_s1_r <= in_p3_y;
    end
  end

  tcbsp_weights u_weights (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .wt      (wt)
  );

  tcbsp_basis u_basis (
    .clk (clk),
    .ctl (ctl),
    .u   (u_s1_r),
    .h   (h)
  );

  tcbsp_axis u_axis_x (
    .clk   (clk),
    .ctl   (ctl),
    .p0    (p0x_s1_r),
    .p1    (p1x_s1_r),
    .p2    (p2x_s1_r),
    .p3    (p3x_s1_r),
    .wt    (wt),
    .h     (h),
    .curve (out_curve_x),
    .clip  (clip_x)
  );

  tcbsp_axis u_axis_y (
    .clk   (clk),
    .ctl   (ctl),
    .p0    (p0y_s1_r),
    .p1    (p1y_s1_r),
    .p2    (p2y_s1_r),
    .p3    (p3y_s1_r),
    .wt    (wt),
    .h     (h),
    .curve (out_curve_y),
    .clip  (clip_y)
  );

  assign out_valid   = out_valid_r;
  assign out_clipped = clip_x || clip_y;

endmodule

`default_nettype wire
